[rtl/sbfc_pkg.sv]
// Shared types, constants and helper functions for the sample batch fault checker.
// No dependencies.
package sbfc_pkg;

    localparam int VAL_W        = 16;
    localparam int CNT_FAULT_W  = 9;
    localparam int BATCH_LENGTH = 256;
    localparam int BATCH_CNT_W  = $clog2(BATCH_LENGTH + 1);
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int S_TDATA_W    = 9 * VAL_W;
    localparam int M_TDATA_W    = 32;

    localparam logic [1:0] MODE_FRESH  = 2'd0;
    localparam logic [1:0] MODE_ACCUM  = 2'd1;
    localparam logic [1:0] MODE_VERIFY = 2'd2;

    localparam logic [1:0] REG_DELAY_REF = 2'd0;
    localparam logic [1:0] REG_DELAY_TOL = 2'd1;
    localparam logic [1:0] REG_SLEW_TOL  = 2'd2;
    localparam logic [1:0] REG_DIFF_TOL  = 2'd3;

    localparam logic [7:0] BIT_READ_COPY  = 8'h80;
    localparam logic [7:0] BIT_WRITE_COPY = 8'h40;
    localparam logic [7:0] BIT_DELAY_COPY = 8'h20;
    localparam logic [7:0] BIT_DELAY      = 8'h10;
    localparam logic [7:0] BIT_SLEW       = 8'h02;
    localparam logic [7:0] BIT_DIFF       = 8'h01;

    localparam logic [CNT_FAULT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic                   bounds_updated;
        logic [CNT_FAULT_W-1:0] diff_fault_count;
        logic [CNT_FAULT_W-1:0] slew_fault_count;
        logic                   any_fault;
        logic [7:0]             fault_bits;
    } result_t;

    typedef struct packed {
        logic    batch_done;
        result_t res;
    } out_word_t;

    function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    // Unsigned window test: v < lo - tol or v > hi + tol
    function automatic logic win_outside(input logic [VAL_W-1:0] v,
                                         input logic [VAL_W-1:0] lo,
                                         input logic [VAL_W-1:0] hi,
                                         input logic [VAL_W-1:0] tol);
        logic [VAL_W:0] v_plus;
        logic [VAL_W:0] hi_plus;
        v_plus  = {1'b0, v} + {1'b0, tol};
        hi_plus = {1'b0, hi} + {1'b0, tol};
        win_outside = (v_plus < {1'b0, lo}) || ({1'b0, v} > hi_plus);
    endfunction

    function automatic logic [CNT_FAULT_W-1:0] bump(input logic [CNT_FAULT_W-1:0] c);
        bump = (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

[rtl/sample_batch_fault_checker.sv]
// Sample batch fault checker: calibration of slew and difference bounds, per-sample
// fault checks, APB register block and a small output queue. Depends on sbfc_pkg.
//
// A result word is registered in the output queue when the input word that causes it is accepted.
// A verify sample's byte leaves with the next sample; a batch's final word follows it.
// Throughput: one input word per cycle, limited by the output queue draining one word
// per cycle (a verify batch's final sample gives two words). Reset clears the batch state,
// the tolerance registers and the queue pointers; no clearing pass.
module sample_batch_fault_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // read_value, written_value, delay_value, read_copy_a, written_copy_a,
    // delay_copy_a, read_copy_b, written_copy_b, delay_copy_b (16 bits each)
    input  logic [sbfc_pkg::S_TDATA_W-1:0] s_tdata,
    // mode
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fault_bits[7:0], any_fault[8], slew_fault_count[17:9],
    // diff_fault_count[26:18], bounds_updated[27], zero fill
    output logic [sbfc_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbfc_pkg::PADDR_W-1:0]  paddr,
    input  logic [sbfc_pkg::PDATA_W-1:0]  pwdata,
    output logic [sbfc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import sbfc_pkg::*;

    logic [VAL_W-1:0] delay_ref_reg, delay_tol_reg, slew_tol_reg, diff_tol_reg;
    logic             cfg_wr;

    logic [VAL_W-1:0] rd, wr, dt, ra, wa, da, rb, wb, db;

    logic [VAL_W-1:0]       prev_read_reg;
    logic                   have_prev_reg, have_prev_next;
    logic [7:0]             pending_reg, pending_next;
    logic [VAL_W-1:0]       slew_min_reg, slew_min_next, slew_max_reg, slew_max_next;
    logic [VAL_W-1:0]       diff_min_reg, diff_min_next, diff_max_reg, diff_max_next;
    logic                   slew_unset_reg, slew_unset_next, diff_unset_reg, diff_unset_next;
    logic                   changed_reg, changed_next;
    logic                   fault_seen_reg, fault_seen_next;
    logic [CNT_FAULT_W-1:0] slew_faults_reg, slew_faults_next;
    logic [CNT_FAULT_W-1:0] diff_faults_reg, diff_faults_next;
    logic [BATCH_CNT_W-1:0] batch_cnt_reg, batch_cnt_next;
    logic [1:0]             batch_mode_reg, batch_mode_next;

    out_word_t              fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  fifo_cnt_reg;

    logic       in_fire, out_fire;
    out_word_t  push0, push1;
    logic [1:0] n_push;

    logic [VAL_W-1:0] slew, diff;
    logic             slew_out, diff_out, delay_bad;
    logic [7:0]       sample_bits;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DELAY_REF: prdata = {{(PDATA_W-VAL_W){1'b0}}, delay_ref_reg};
            REG_DELAY_TOL: prdata = {{(PDATA_W-VAL_W){1'b0}}, delay_tol_reg};
            REG_SLEW_TOL:  prdata = {{(PDATA_W-VAL_W){1'b0}}, slew_tol_reg};
            REG_DIFF_TOL:  prdata = {{(PDATA_W-VAL_W){1'b0}}, diff_tol_reg};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ref_reg <= '0;
            delay_tol_reg <= '0;
            slew_tol_reg  <= '0;
            diff_tol_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_DELAY_REF: delay_ref_reg <= pwdata[VAL_W-1:0];
                REG_DELAY_TOL: delay_tol_reg <= pwdata[VAL_W-1:0];
                REG_SLEW_TOL:  slew_tol_reg  <= pwdata[VAL_W-1:0];
                REG_DIFF_TOL:  diff_tol_reg  <= pwdata[VAL_W-1:0];
                default:       ;
            endcase
        end
    end

    // Unpack the input word
    assign rd = s_tdata[0*VAL_W +: VAL_W];
    assign wr = s_tdata[1*VAL_W +: VAL_W];
    assign dt = s_tdata[2*VAL_W +: VAL_W];
    assign ra = s_tdata[3*VAL_W +: VAL_W];
    assign wa = s_tdata[4*VAL_W +: VAL_W];
    assign da = s_tdata[5*VAL_W +: VAL_W];
    assign rb = s_tdata[6*VAL_W +: VAL_W];
    assign wb = s_tdata[7*VAL_W +: VAL_W];
    assign db = s_tdata[8*VAL_W +: VAL_W];

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    assign slew      = have_prev_reg ? abs_diff(rd, prev_read_reg) : '0;
    assign diff      = abs_diff(wr, rd);
    assign slew_out  = win_outside(slew, slew_min_reg, slew_max_reg, slew_tol_reg);
    assign diff_out  = win_outside(diff, diff_min_reg, diff_max_reg, diff_tol_reg);
    assign delay_bad = abs_diff(dt, delay_ref_reg) >= delay_tol_reg;

    always_comb
    begin
        sample_bits = '0;
        if (!(rd == ra && ra == rb)) sample_bits = sample_bits | BIT_READ_COPY;
        if (!(wr == wa && wa == wb)) sample_bits = sample_bits | BIT_WRITE_COPY;
        if (!(dt == da && da == db)) sample_bits = sample_bits | BIT_DELAY_COPY;
        if (delay_bad)               sample_bits = sample_bits | BIT_DELAY;
        if (diff_out)                sample_bits = sample_bits | BIT_DIFF;
    end

    // Per-sample update
    always_comb
    begin
        logic                   first;
        logic                   last;
        logic [BATCH_CNT_W-1:0] cnt_inc;

        have_prev_next   = have_prev_reg;
        pending_next     = pending_reg;
        slew_min_next    = slew_min_reg;
        slew_max_next    = slew_max_reg;
        diff_min_next    = diff_min_reg;
        diff_max_next    = diff_max_reg;
        slew_unset_next  = slew_unset_reg;
        diff_unset_next  = diff_unset_reg;
        changed_next     = changed_reg;
        fault_seen_next  = fault_seen_reg;
        slew_faults_next = slew_faults_reg;
        diff_faults_next = diff_faults_reg;
        batch_cnt_next   = batch_cnt_reg;
        batch_mode_next  = batch_mode_reg;
        push0            = '0;
        push1            = '0;
        n_push           = 2'd0;
        first            = !have_prev_reg;
        cnt_inc          = (first ? '0 : batch_cnt_reg) + 1'b1;
        last             = s_tlast || (cnt_inc >= BATCH_CNT_W'(BATCH_LENGTH));

        if (in_fire)
        begin
            batch_cnt_next = cnt_inc;
            if (first)
            begin
                batch_mode_next  = s_tuser;
                changed_next     = 1'b0;
                fault_seen_next  = 1'b0;
                slew_faults_next = '0;
                diff_faults_next = '0;
                if (s_tuser == MODE_FRESH)
                begin
                    slew_unset_next = 1'b1;
                    diff_unset_next = 1'b1;
                    changed_next    = 1'b1;
                end
            end

            if (batch_mode_next <= MODE_ACCUM)
            begin
                // Learn bounds
                if (have_prev_reg)
                begin
                    if (slew_unset_next)
                    begin
                        slew_min_next   = slew;
                        slew_max_next   = slew;
                        slew_unset_next = 1'b0;
                        changed_next    = 1'b1;
                    end
                    else
                    begin
                        if (slew > slew_max_reg)
                        begin
                            slew_max_next = slew;
                            changed_next  = 1'b1;
                        end
                        if (slew < slew_min_reg)
                        begin
                            slew_min_next = slew;
                            changed_next  = 1'b1;
                        end
                    end
                end
                if (diff_unset_next)
                begin
                    diff_min_next   = diff;
                    diff_max_next   = diff;
                    diff_unset_next = 1'b0;
                    changed_next    = 1'b1;
                end
                else
                begin
                    if (diff > diff_max_reg)
                    begin
                        diff_max_next = diff;
                        changed_next  = 1'b1;
                    end
                    if (diff < diff_min_reg)
                    begin
                        diff_min_next = diff;
                        changed_next  = 1'b1;
                    end
                end
                if (last)
                begin
                    fault_seen_next          = 1'b0;
                    slew_faults_next         = '0;
                    diff_faults_next         = '0;
                    push0.batch_done         = 1'b1;
                    push0.res.bounds_updated = changed_next;
                    n_push                   = 2'd1;
                end
            end
            else
            begin
                // Verify: release the held byte, then check this sample
                if (have_prev_reg)
                begin
                    if (slew_out)
                    begin
                        pending_next     = pending_reg | BIT_SLEW;
                        slew_faults_next = bump(slew_faults_reg);
                        fault_seen_next  = 1'b1;
                    end
                    push0.res.fault_bits       = pending_next;
                    push0.res.any_fault        = fault_seen_next;
                    push0.res.slew_fault_count = slew_faults_next;
                    push0.res.diff_fault_count = diff_faults_next;
                    n_push                     = 2'd1;
                end
                if (diff_out)
                    diff_faults_next = bump(diff_faults_next);
                if (sample_bits != '0)
                    fault_seen_next = 1'b1;
                pending_next = sample_bits;
                if (last)
                begin
                    push1.batch_done           = 1'b1;
                    push1.res.fault_bits       = sample_bits;
                    push1.res.any_fault        = fault_seen_next;
                    push1.res.slew_fault_count = slew_faults_next;
                    push1.res.diff_fault_count = diff_faults_next;
                    if (have_prev_reg)
                        n_push = 2'd2;
                    else
                    begin
                        push0  = push1;
                        n_push = 2'd1;
                    end
                end
            end

            if (last)
            begin
                have_prev_next = 1'b0;
                pending_next   = '0;
                batch_cnt_next = '0;
            end
            else
                have_prev_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_read_reg   <= '0;
            have_prev_reg   <= 1'b0;
            pending_reg     <= '0;
            slew_min_reg    <= '0;
            slew_max_reg    <= '0;
            diff_min_reg    <= '0;
            diff_max_reg    <= '0;
            slew_unset_reg  <= 1'b1;
            diff_unset_reg  <= 1'b1;
            changed_reg     <= 1'b0;
            fault_seen_reg  <= 1'b0;
            slew_faults_reg <= '0;
            diff_faults_reg <= '0;
            batch_cnt_reg   <= '0;
            batch_mode_reg  <= MODE_FRESH;
        end
        else
        begin
            if (in_fire)
                prev_read_reg <= rd;
            have_prev_reg   <= have_prev_next;
            pending_reg     <= pending_next;
            slew_min_reg    <= slew_min_next;
            slew_max_reg    <= slew_max_next;
            diff_min_reg    <= diff_min_next;
            diff_max_reg    <= diff_max_next;
            slew_unset_reg  <= slew_unset_next;
            diff_unset_reg  <= diff_unset_next;
            changed_reg     <= changed_next;
            fault_seen_reg  <= fault_seen_next;
            slew_faults_reg <= slew_faults_next;
            diff_faults_reg <= diff_faults_next;
            batch_cnt_reg   <= batch_cnt_next;
            batch_mode_reg  <= batch_mode_next;
        end
    end

    // Output queue
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            fifo_reg[wr_ptr_reg] <= push0;
        if (n_push == 2'd2)
            fifo_reg[wr_ptr_reg + 1'b1] <= push1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + FIFO_PTR_W'(n_push);
            rd_ptr_reg   <= rd_ptr_reg + FIFO_PTR_W'(out_fire);
            fifo_cnt_reg <= fifo_cnt_reg + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(out_fire);
        end
    end

    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {{(M_TDATA_W - $bits(result_t)){1'b0}}, fifo_reg[rd_ptr_reg].res};
    assign m_tlast  = fifo_reg[rd_ptr_reg].batch_done;

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overfilled");

    a_batch_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg == (batch_cnt_reg != '0))
        else $error("batch count out of step with sample history");

    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !have_prev_reg |-> pending_reg == '0)
        else $error("held fault byte outside a batch");

    a_slew_order: assert property (@(posedge clk) disable iff (!rst_n)
        slew_min_reg <= slew_max_reg)
        else $error("slew bounds inverted");

    a_diff_order: assert property (@(posedge clk) disable iff (!rst_n)
        diff_min_reg <= diff_max_reg)
        else $error("difference bounds inverted");

endmodule
